// File: sv/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg
// Shared constants and types for the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int CMDW  = 4;
    localparam int CHARW = 8;
    localparam int CAPW  = 7;
    localparam int POSW  = 7;

    localparam logic [CMDW-1:0] CMD_INSERT = 4'd0;
    localparam logic [CMDW-1:0] CMD_BACK   = 4'd1;
    localparam logic [CMDW-1:0] CMD_DEL    = 4'd2;
    localparam logic [CMDW-1:0] CMD_LEFT   = 4'd3;
    localparam logic [CMDW-1:0] CMD_RIGHT  = 4'd4;
    localparam logic [CMDW-1:0] CMD_HOME   = 4'd5;
    localparam logic [CMDW-1:0] CMD_END    = 4'd6;
    localparam logic [CMDW-1:0] CMD_CLEAR  = 4'd7;
    localparam logic [CMDW-1:0] CMD_NOP    = 4'd8;

    localparam logic [CHARW-1:0] CHAR_FIRST = 8'h20;
    localparam logic [CHARW-1:0] CHAR_LAST  = 8'h7E;

    localparam logic [CAPW-1:0] CAP_RESET = 7'd64;

    // shift operation broadcast along the cell row
    typedef enum logic [1:0] {
        ED_NONE,
        ED_INS,
        ED_DEL
    } t_edit_op;

endpackage

// File: sv/leb_if.sv
// ----------------------------------------------------------------------------
// leb_if
// Valid/ready channels of the line edit buffer: request, result, config.
// ----------------------------------------------------------------------------
interface leb_req_if;
    import leb_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMDW-1:0]  cmd;
    logic [CHARW-1:0] key_char;
    modport source (output valid, output cmd, output key_char, input ready);
    modport sink   (input valid, input cmd, input key_char, output ready);
endinterface

interface leb_rsp_if;
    import leb_pkg::*;
    logic             valid;
    logic             ready;
    logic             accepted;
    logic [POSW-1:0]  cursor_pos;
    logic [POSW-1:0]  text_len;
    logic [CHARW-1:0] char_at_cursor;
    modport source (output valid, output accepted, output cursor_pos, output text_len,
                    output char_at_cursor, input ready);
    modport sink   (input valid, input accepted, input cursor_pos, input text_len,
                    input char_at_cursor, output ready);
endinterface

interface leb_cfg_if;
    import leb_pkg::*;
    logic            valid;
    logic            ready;
    logic [CAPW-1:0] capacity;
    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// File: sv/leb_cell.sv
// ----------------------------------------------------------------------------
// leb_cell
// One character slot of the edit row; shifts with its neighbors on edits.
// ----------------------------------------------------------------------------
module leb_cell
    import leb_pkg::*;
#(
    parameter int IDX = 0,
    parameter int LW  = 7
) (
    input  logic             i_clk,
    input  t_edit_op         i_op,
    input  logic [LW-1:0]    i_pos,
    input  logic [LW-1:0]    i_len,
    input  logic [CHARW-1:0] i_key,
    input  logic [CHARW-1:0] i_left,
    input  logic [CHARW-1:0] i_right,
    output logic [CHARW-1:0] o_char
);

    logic [CHARW-1:0] r_char;
    logic [CHARW-1:0] n_char;
    logic [LW:0]      idx_ext;
    logic [LW:0]      pos_ext;
    logic [LW:0]      len_ext;

    assign idx_ext = (LW+1)'(IDX);
    assign pos_ext = {1'b0, i_pos};
    assign len_ext = {1'b0, i_len};

    always_comb begin
        n_char = r_char;
        case (i_op)
            ED_INS: begin
                if (idx_ext == pos_ext) begin
                    n_char = i_key;
                end else if (idx_ext > pos_ext) begin
                    n_char = i_left;
                end
            end
            ED_DEL: begin
                if (idx_ext >= pos_ext && (idx_ext + 1'b1) < len_ext) begin
                    n_char = i_right;
                end
            end
            default: n_char = r_char;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

    assign o_char = r_char;

endmodule

// File: sv/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer
// Single-line edit buffer with a cursor, built as a row of character cells.
//
// Channels: i_req takes one edit command and a key character per request;
// o_rsp returns one result per request (accepted flag, cursor, length and
// the character under the cursor); i_cfg writes the capacity register and is
// always ready.
// Operation: when a request is taken, the cursor and length registers update
// and every cell loads from its left or right neighbor or the key at once, so
// inserts and deletes anywhere cost the same; then, once the result register
// is free, the character at the new cursor is read from the row into the
// result register. No new request is taken until the result of the last one
// has been loaded into the result register.
// Stall: while a result waits on o_rsp, one more request may be taken; it
// then holds until the result register frees and no further request is taken.
// Reset: length, cursor and handshake state clear, capacity returns to 64;
// the cell contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module line_edit_buffer
    import leb_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    leb_req_if.sink   i_req,
    leb_rsp_if.source o_rsp,
    leb_cfg_if.sink   i_cfg
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = (LW > CAPW) ? LW : CAPW;

    logic [CAPW-1:0]  r_capacity;
    logic [LW-1:0]    r_cursor;
    logic [LW-1:0]    r_len;
    logic             r_busy;
    logic             r_ok;
    logic             r_out_valid;
    logic             r_out_ok;
    logic [POSW-1:0]  r_out_cursor;
    logic [POSW-1:0]  r_out_len;
    logic [CHARW-1:0] r_out_char;

    logic [LW-1:0]    n_cursor;
    logic [LW-1:0]    n_len;
    logic             n_ok;
    t_edit_op         edit_op;
    logic [LW-1:0]    edit_pos;
    logic             req_fire;
    logic             rsp_free;
    logic [CW-1:0]    cap_eff;
    logic [CW-1:0]    cap_ext;
    logic             printable;
    logic [CHARW-1:0] cell_char [MAX_LEN];
    logic [CHARW-1:0] read_char;

    assign rsp_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_busy;
    assign req_fire    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign cap_ext   = CW'(r_capacity);
    assign cap_eff   = (cap_ext > CW'(MAX_LEN)) ? CW'(MAX_LEN) : cap_ext;
    assign printable = i_req.key_char >= CHAR_FIRST && i_req.key_char <= CHAR_LAST;

    always_comb begin
        n_cursor = r_cursor;
        n_len    = r_len;
        n_ok     = 1'b0;
        edit_op  = ED_NONE;
        edit_pos = r_cursor;
        case (i_req.cmd)
            CMD_INSERT: begin
                if (CW'(r_len) < cap_eff && printable) begin
                    n_ok     = 1'b1;
                    edit_op  = ED_INS;
                    n_cursor = r_cursor + 1'b1;
                    n_len    = r_len + 1'b1;
                end
            end
            CMD_BACK: begin
                if (r_cursor != '0) begin
                    n_ok     = 1'b1;
                    edit_op  = ED_DEL;
                    edit_pos = r_cursor - 1'b1;
                    n_cursor = r_cursor - 1'b1;
                    n_len    = r_len - 1'b1;
                end
            end
            CMD_DEL: begin
                if (r_cursor < r_len) begin
                    n_ok    = 1'b1;
                    edit_op = ED_DEL;
                    n_len   = r_len - 1'b1;
                end
            end
            CMD_LEFT: begin
                if (r_cursor != '0) begin
                    n_ok     = 1'b1;
                    n_cursor = r_cursor - 1'b1;
                end
            end
            CMD_RIGHT: begin
                if (r_cursor < r_len) begin
                    n_ok     = 1'b1;
                    n_cursor = r_cursor + 1'b1;
                end
            end
            CMD_HOME: begin
                n_ok     = 1'b1;
                n_cursor = '0;
            end
            CMD_END: begin
                n_ok     = 1'b1;
                n_cursor = r_len;
            end
            CMD_CLEAR: begin
                n_ok     = 1'b1;
                n_cursor = '0;
                n_len    = '0;
            end
            CMD_NOP: n_ok = 1'b1;
            default: n_ok = 1'b0;
        endcase
        if (!req_fire) begin
            edit_op = ED_NONE;
        end
    end

    // cell row, each cell sees its neighbors; the end cells see zero beyond the row
    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        logic [CHARW-1:0] left_char;
        logic [CHARW-1:0] right_char;
        if (g == 0) begin : g_first
            assign left_char = '0;
        end else begin : g_mid_l
            assign left_char = cell_char[g-1];
        end
        if (g == MAX_LEN - 1) begin : g_last
            assign right_char = '0;
        end else begin : g_mid_r
            assign right_char = cell_char[g+1];
        end
        leb_cell #(
            .IDX (g),
            .LW  (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (edit_op),
            .i_pos   (edit_pos),
            .i_len   (r_len),
            .i_key   (i_req.key_char),
            .i_left  (left_char),
            .i_right (right_char),
            .o_char  (cell_char[g])
        );
    end

    assign read_char = (r_cursor < r_len) ? cell_char[r_cursor[IW-1:0]] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_cursor    <= '0;
            r_len       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.capacity;
            end
            if (req_fire) begin
                r_cursor <= n_cursor;
                r_len    <= n_len;
                r_busy   <= 1'b1;
            end else if (r_busy && rsp_free) begin
                r_busy <= 1'b0;
            end
            if (r_busy && rsp_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_ok <= n_ok;
        end
        if (r_busy && rsp_free) begin
            r_out_ok     <= r_ok;
            r_out_cursor <= POSW'(r_cursor);
            r_out_len    <= POSW'(r_len);
            r_out_char   <= read_char;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.accepted       = r_out_ok;
    assign o_rsp.cursor_pos     = r_out_cursor;
    assign o_rsp.text_len       = r_out_len;
    assign o_rsp.char_at_cursor = r_out_char;

    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_len)
        else $error("cursor beyond end of text");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_LEN))
        else $error("length beyond buffer size");

    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> r_busy && !i_req.ready)
        else $error("request taken without going busy");

    a_rsp_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result without a pending request");

endmodule

// File: tb/line_edit_buffer_tb.sv
// ----------------------------------------------------------------------------
// line_edit_buffer_tb
// Self-checking bench for the line edit buffer. A directed table covers the
// rejected edits, the printable range limits and every command; random
// phases follow at several capacities (0, 1, 127, 64, a capacity below the
// held text and a random one) with bursty requests and a stalling result sink.
// Results are checked against the table's values or a local model of the buffer.
// ----------------------------------------------------------------------------
module line_edit_buffer_tb;
    import leb_pkg::*;

    localparam int BUF_DEPTH      = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;

    localparam logic [CMDW-1:0] CMD_UNKNOWN_LO = CMD_NOP + 4'd1;
    localparam logic [CMDW-1:0] CMD_UNKNOWN_HI = 4'hF;

    typedef struct packed {
        logic             accepted;
        logic [POSW-1:0]  cursor_pos;
        logic [POSW-1:0]  text_len;
        logic [CHARW-1:0] char_at_cursor;
    } t_status;

    typedef struct packed {
        logic [CMDW-1:0]  cmd;
        logic [CHARW-1:0] key;
        logic             typed;
        t_status          want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic sink_ready = 1'b0;

    leb_req_if req_if ();
    leb_rsp_if rsp_if ();
    leb_cfg_if cfg_if ();

    assign rsp_if.ready = sink_ready;

    line_edit_buffer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model of the buffer
    logic [CHARW-1:0] line_text [BUF_DEPTH];
    int               line_len;
    int               line_cur;
    logic [CAPW-1:0]  line_cap;

    t_status pending_status [$];
    t_row    plan [$];

    logic    want_typed;
    t_status want_status;

    int n_mismatch = 0;
    int n_req      = 0;
    int n_rsp      = 0;
    int n_cfg      = 0;
    int n_rejected = 0;
    int peak_len   = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    logic [15:0] stall_mask = 16'hFFFF;
    int          stall_tick = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        n_mismatch++;
    endtask

    function automatic void drop_char(input int pos);
        for (int i = pos; i < line_len - 1; i++) line_text[i] = line_text[i + 1];
        line_len--;
    endfunction

    function automatic t_status apply_edit(input logic [CMDW-1:0] cmd,
                                           input logic [CHARW-1:0] key);
        t_status s;
        logic    ok;
        int      room;
        ok   = 1'b0;
        room = (line_cap > BUF_DEPTH) ? BUF_DEPTH : int'(line_cap);
        case (cmd)
            CMD_INSERT: begin
                if (line_len < room && key >= CHAR_FIRST && key <= CHAR_LAST) begin
                    for (int i = line_len; i > line_cur; i--) line_text[i] = line_text[i - 1];
                    line_text[line_cur] = key;
                    line_len++;
                    line_cur++;
                    ok = 1'b1;
                end
            end
            CMD_BACK: begin
                if (line_cur > 0) begin
                    line_cur--;
                    drop_char(line_cur);
                    ok = 1'b1;
                end
            end
            CMD_DEL: begin
                if (line_cur < line_len) begin
                    drop_char(line_cur);
                    ok = 1'b1;
                end
            end
            CMD_LEFT: begin
                if (line_cur > 0) begin
                    line_cur--;
                    ok = 1'b1;
                end
            end
            CMD_RIGHT: begin
                if (line_cur < line_len) begin
                    line_cur++;
                    ok = 1'b1;
                end
            end
            CMD_HOME: begin
                line_cur = 0;
                ok = 1'b1;
            end
            CMD_END: begin
                line_cur = line_len;
                ok = 1'b1;
            end
            CMD_CLEAR: begin
                line_len = 0;
                line_cur = 0;
                ok = 1'b1;
            end
            CMD_NOP: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        s.accepted       = ok;
        s.cursor_pos     = POSW'(line_cur);
        s.text_len       = POSW'(line_len);
        s.char_at_cursor = (line_cur < line_len) ? line_text[line_cur] : '0;
        return s;
    endfunction

    // request and result monitor
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        t_status pred;
        if (!i_rst_n) begin
            line_len = 0;
            line_cur = 0;
            line_cap = CAP_RESET;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.accepted, rsp_if.cursor_pos, rsp_if.text_len,
                       rsp_if.char_at_cursor};
                if (pending_status.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request waiting", n_rsp));
                end else begin
                    want = pending_status.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch($sformatf("result %0d accepted got %0h want %0h",
                                                  n_rsp, got.accepted, want.accepted));
                    if (got.cursor_pos !== want.cursor_pos)
                        report_mismatch($sformatf("result %0d cursor_pos got %0d want %0d",
                                                  n_rsp, got.cursor_pos, want.cursor_pos));
                    if (got.text_len !== want.text_len)
                        report_mismatch($sformatf("result %0d text_len got %0d want %0d",
                                                  n_rsp, got.text_len, want.text_len));
                    if (got.char_at_cursor !== want.char_at_cursor)
                        report_mismatch($sformatf("result %0d char_at_cursor got %0h want %0h",
                                                  n_rsp, got.char_at_cursor,
                                                  want.char_at_cursor));
                end
                n_rsp++;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                line_cap = cfg_if.capacity;
                n_cfg++;
            end
            if (req_if.valid && req_if.ready) begin
                pred = apply_edit(req_if.cmd, req_if.key_char);
                if (!pred.accepted) n_rejected++;
                if (line_len > peak_len) peak_len = line_len;
                pending_status.push_back(want_typed ? want_status : pred);
                n_req++;
            end
        end
    end

    // result sink stall pattern
    always @(posedge i_clk) begin
        if (stall_tick % 64 == 0)
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
        sink_ready <= stall_mask[stall_tick % 16];
        stall_tick++;
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("line_edit_buffer_tb NOT OK");
            $finish;
        end
    end

    task automatic idle_req(input int n);
        req_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) idle_req(gap);
        end
        burst_left--;
    endtask

    task automatic send_req(input logic [CMDW-1:0] cmd, input logic [CHARW-1:0] key,
                            input logic typed, input t_status want);
        pace_sender();
        req_if.valid    <= 1'b1;
        req_if.cmd      <= cmd;
        req_if.key_char <= key;
        want_typed      <= typed;
        want_status     <= want;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    task automatic wait_results_done();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAPW-1:0] cap);
        wait_results_done();
        cfg_if.valid    <= 1'b1;
        cfg_if.capacity <= cap;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic row(input logic [CMDW-1:0] cmd, input logic [CHARW-1:0] key,
                       input logic typed, input logic acc, input int cur, input int len,
                       input logic [CHARW-1:0] ch);
        t_row r;
        r.cmd  = cmd;
        r.key  = key;
        r.typed = typed;
        r.want = {acc, POSW'(cur), POSW'(len), ch};
        plan.push_back(r);
    endtask

    task automatic run_phase(input logic [CAPW-1:0] cap, input int n_items,
                             input int clear_pct);
        logic [CMDW-1:0]  cmd;
        logic [CHARW-1:0] key;
        int               pick;
        set_capacity(cap);
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            key  = CHARW'($urandom_range(0, 255));
            if (pick < clear_pct) cmd = CMD_CLEAR;
            else if (pick < 50) begin
                cmd = CMD_INSERT;
                if ($urandom_range(0, 9) != 0)
                    key = CHARW'($urandom_range(CHAR_FIRST, CHAR_LAST));
            end
            else if (pick < 60) cmd = CMD_BACK;
            else if (pick < 68) cmd = CMD_DEL;
            else if (pick < 76) cmd = CMD_LEFT;
            else if (pick < 84) cmd = CMD_RIGHT;
            else if (pick < 88) cmd = CMD_HOME;
            else if (pick < 92) cmd = CMD_END;
            else if (pick < 96) cmd = CMD_NOP;
            else cmd = CMDW'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
            send_req(cmd, key, 1'b0, '0);
            if ($urandom_range(0, 59) == 0) wait_results_done();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.cmd      = CMD_NOP;
        req_if.key_char = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.capacity = CAP_RESET;
        want_typed      = 1'b0;
        want_status     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        //  cmd         key                typed acc cur len char
        row(CMD_NOP,    8'h00,             1, 1, 0, 0, 8'h00);
        row(CMD_BACK,   8'h00,             1, 0, 0, 0, 8'h00);
        row(CMD_DEL,    8'hFF,             1, 0, 0, 0, 8'h00);
        row(CMD_LEFT,   8'h00,             1, 0, 0, 0, 8'h00);
        row(CMD_RIGHT,  8'hFF,             1, 0, 0, 0, 8'h00);
        row(CMD_INSERT, CHAR_FIRST - 8'd1, 1, 0, 0, 0, 8'h00);
        row(CMD_INSERT, CHAR_LAST + 8'd1,  1, 0, 0, 0, 8'h00);
        row(CMD_INSERT, CHAR_FIRST,        1, 1, 1, 1, 8'h00);
        row(CMD_INSERT, CHAR_LAST,         1, 1, 2, 2, 8'h00);
        row(CMD_HOME,   8'h00,             1, 1, 0, 2, CHAR_FIRST);
        row(CMD_INSERT, 8'h41,             0, 0, 0, 0, 8'h00);
        row(CMD_END,    8'h00,             1, 1, 3, 3, 8'h00);
        row(CMD_LEFT,   8'h00,             0, 0, 0, 0, 8'h00);
        row(CMD_BACK,   8'h00,             0, 0, 0, 0, 8'h00);
        row(CMD_INSERT, 8'h55,             0, 0, 0, 0, 8'h00);
        row(CMD_HOME,   8'h00,             0, 0, 0, 0, 8'h00);
        row(CMD_DEL,    8'h00,             0, 0, 0, 0, 8'h00);
        row(CMD_RIGHT,  8'h00,             0, 0, 0, 0, 8'h00);
        row(CMD_INSERT, 8'hFF,             0, 0, 0, 0, 8'h00);
        row(CMD_UNKNOWN_LO, 8'h00,         0, 0, 0, 0, 8'h00);
        row(CMD_UNKNOWN_HI, 8'hFF,         0, 0, 0, 0, 8'h00);
        row(CMD_CLEAR,  8'h00,             1, 1, 0, 0, 8'h00);
        row(CMD_END,    8'h00,             1, 1, 0, 0, 8'h00);
        row(CMD_HOME,   8'h00,             1, 1, 0, 0, 8'h00);

        foreach (plan[i]) send_req(plan[i].cmd, plan[i].key, plan[i].typed, plan[i].want);

        // capacity 127 saturates at the buffer depth; 5 lands below the held text
        run_phase(7'd1,   80,  3);
        run_phase(7'd0,   40,  3);
        run_phase(7'd127, 250, 0);
        run_phase(CAP_RESET, 150, 0);
        run_phase(7'd5,   80,  2);
        run_phase(CAPW'($urandom_range(1, BUF_DEPTH)), 120, 2);

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_status.size()));

        $display("covered %0d edit requests (%0d rejected), %0d results, %0d capacity writes",
                 n_req, n_rejected, n_rsp, n_cfg);
        $display("longest text held: %0d characters, mismatches: %0d", peak_len, n_mismatch);
        if (n_mismatch == 0)
            $display("line_edit_buffer_tb OK");
        else
            $display("line_edit_buffer_tb NOT OK");
        $finish;
    end

endmodule

// File: line_edit_buffer.f
sv/leb_pkg.sv
sv/leb_if.sv
sv/leb_cell.sv
sv/line_edit_buffer.sv
tb/line_edit_buffer_tb.sv
